// ===== design/dfc_pkg.sv =====
package dfc_pkg;

    // Default size of the forest.
    localparam int FOREST_SIZE_DEF = 10;

    // Heap depth of every tree; a node at this depth always acts as a leaf.
    localparam int TREE_DEPTH = 3;

    // Fixed field sizes of the stream payload.
    localparam int FEATURE_CNT  = 4;
    localparam int NUM_CLASSES  = 4;
    localparam int FEAT_W       = 16;
    localparam int FIDX_W       = 2;
    localparam int CLASS_W      = 2;
    localparam int TCOUNT_W     = 4;

    // Reset value of the tree count register.
    localparam logic [TCOUNT_W-1:0] TREE_COUNT_RESET = 4'd10;

    // Item kinds carried in tuser.
    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    // One stored tree node, leaf flag in the lowest bit.
    typedef struct packed {
        logic [CLASS_W-1:0]       cls;
        logic signed [FEAT_W-1:0] thr;
        logic [FIDX_W-1:0]        feat;
        logic                     leaf;
    } node_t;

    // Control from the sequencer to the vote tally.
    typedef struct packed {
        logic               clear;
        logic               inc;
        logic [CLASS_W-1:0] cls;
    } vote_ctl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ===== design/dfc_node_mem.sv =====
module dfc_node_mem #(
    parameter int DEPTH  = 160,
    parameter int ADDR_W = 8
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  dfc_pkg::node_t        wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output dfc_pkg::node_t        rd_data
);

    dfc_pkg::node_t mem [DEPTH];
    dfc_pkg::node_t rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dfc_vote_tally.sv =====
module dfc_vote_tally #(
    parameter int VOTE_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dfc_pkg::vote_ctl_t            ctl,
    output logic [dfc_pkg::CLASS_W-1:0]   best_class,
    output logic [VOTE_W-1:0]             best_votes
);

    logic [VOTE_W-1:0] cnt_reg [dfc_pkg::NUM_CLASSES];

    // Per-class vote counters, cleared at the start of each sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < dfc_pkg::NUM_CLASSES; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int c = 0; c < dfc_pkg::NUM_CLASSES; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else if (ctl.inc)
        begin
            cnt_reg[ctl.cls] <= cnt_reg[ctl.cls] + VOTE_W'(1);
        end
    end

    // Majority pick; a strict compare keeps the smallest class on ties.
    always_comb
    begin
        best_class = '0;
        best_votes = cnt_reg[0];
        for (int c = 1; c < dfc_pkg::NUM_CLASSES; c++)
        begin
            if (cnt_reg[c] > best_votes)
            begin
                best_votes = cnt_reg[c];
                best_class = dfc_pkg::CLASS_W'(c);
            end
        end
    end

endmodule

// ===== design/decision_forest_classifier.sv =====
// Decision forest classifier.
// Input stream (s_*): tuser selects the kind of transaction. A write
// transaction (tuser 0) stores one tree node in the node memory; it gives no
// result. A classify transaction (tuser 1) walks trees 0 .. tree_count-1,
// clamped to the stored trees (tree 0 alone if tree_count is 0), from their
// roots and gives one result on the output stream (m_*): the majority class
// and its vote count. The walk reads one node per cycle from the single
// node memory port, visiting between one and four nodes per tree, and then
// hands off the result.
// s_tready is low while a sample is being walked, so one transaction is in
// work at a time.
// The result sits in an output register; while the receiver stalls, new
// transactions are still accepted, and a finished classification waits
// until that register is free.
// The configuration write (cfg_we, cfg_wdata) sets tree_count and must be
// done while the block is idle.
// Reset sets tree_count to 10 and empties the output register. Node memory
// is not cleared; each node must be written before a sample can reach it.
module decision_forest_classifier #(
    parameter int FOREST_SIZE = dfc_pkg::FOREST_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: tree_index[3:0], node_slot[7:4], node_is_leaf[8],
    // node_feature[10:9], node_threshold[26:11], node_class[28:27],
    // feature_0[44:29], feature_1[60:45], feature_2[76:61],
    // feature_3[92:77], zero pad[95:93].
    input  logic [95:0] s_tdata,
    // s_tuser: mode[0].
    input  logic [0:0]  s_tuser,
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low bit up: majority class[1:0], winning_votes[5:2],
    // zero pad[7:6].
    output logic [7:0]  m_tdata,
    // Configuration write of tree_count.
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);

    localparam int TREE_DEPTH = dfc_pkg::TREE_DEPTH;
    localparam int STRIDE    = 2 ** (TREE_DEPTH + 1);
    localparam int LAST_SLOT = STRIDE - 2;
    localparam int SLOT_W    = TREE_DEPTH + 1;
    localparam int TREE_W    = (FOREST_SIZE > 1) ? $clog2(FOREST_SIZE) : 1;
    localparam int ADDR_W    = TREE_W + SLOT_W;
    localparam int MEM_DEPTH = FOREST_SIZE * STRIDE;
    localparam int DEPTH_W   = $clog2(TREE_DEPTH + 1);
    localparam int VOTE_W    = $clog2(FOREST_SIZE + 1);
    localparam int FW        = dfc_pkg::FEAT_W;

    dfc_pkg::state_t state_reg, state_next;

    logic [dfc_pkg::TCOUNT_W-1:0] tree_count_reg;
    logic signed [FW-1:0]         feat_reg [dfc_pkg::FEATURE_CNT];
    logic [TREE_W-1:0]            tree_reg, tree_next;
    logic [TREE_W-1:0]            last_reg, last_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [DEPTH_W-1:0]           depth_reg, depth_next;

    logic                         m_tvalid_reg;
    logic [dfc_pkg::CLASS_W-1:0]  m_class_reg;
    logic [VOTE_W-1:0]            m_votes_reg;

    logic                         s_accept;
    logic                         is_classify;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    dfc_pkg::node_t               wr_node;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    dfc_pkg::node_t               node;
    logic [TREE_W-1:0]            n_last;
    logic signed [FW-1:0]         sel_value;
    logic                         go_left;
    logic [SLOT_W-1:0]            child_slot;
    logic                         walk_end;
    logic [dfc_pkg::CLASS_W-1:0]  leaf_class;
    logic                         out_free;
    logic                         out_load;
    dfc_pkg::vote_ctl_t           vote_ctl;
    logic [dfc_pkg::CLASS_W-1:0]  best_class;
    logic [VOTE_W-1:0]            best_votes;

    assign s_tready    = (state_reg == dfc_pkg::ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign is_classify = (s_tuser[0] == dfc_pkg::MODE_CLASSIFY);
    assign out_free    = !m_tvalid_reg || m_tready;

    // Node write path; writes outside the table are dropped.
    assign wr_node.leaf = s_tdata[8];
    assign wr_node.feat = s_tdata[10:9];
    assign wr_node.thr  = s_tdata[26:11];
    assign wr_node.cls  = s_tdata[28:27];
    assign wr_addr      = {TREE_W'(s_tdata[3:0]), SLOT_W'(s_tdata[7:4])};
    assign wr_en        = s_accept && !is_classify
                          && (32'(s_tdata[3:0]) < FOREST_SIZE)
                          && (32'(s_tdata[7:4]) <= LAST_SLOT);

    // Tree count clamped to the range of stored trees, as a last index.
    always_comb
    begin
        if (tree_count_reg == '0)
        begin
            n_last = '0;
        end
        else if (32'(tree_count_reg) > FOREST_SIZE)
        begin
            n_last = TREE_W'(FOREST_SIZE - 1);
        end
        else
        begin
            n_last = TREE_W'(tree_count_reg - 4'd1);
        end
    end

    // Shared compare unit: selected feature against the node threshold.
    always_comb
    begin
        if (32'(node.feat) < dfc_pkg::FEATURE_CNT)
        begin
            sel_value = feat_reg[node.feat];
        end
        else
        begin
            sel_value = '0;
        end
        go_left    = (sel_value < node.thr);
        child_slot = (slot_reg << 1) + (go_left ? SLOT_W'(1) : SLOT_W'(2));
        walk_end   = node.leaf || (depth_reg == DEPTH_W'(TREE_DEPTH));
        if (32'(node.cls) >= dfc_pkg::NUM_CLASSES)
        begin
            leaf_class = dfc_pkg::CLASS_W'(dfc_pkg::NUM_CLASSES - 1);
        end
        else
        begin
            leaf_class = node.cls;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dfc_pkg::ST_IDLE:
            begin
                if (s_tvalid && is_classify)
                begin
                    state_next = dfc_pkg::ST_WALK;
                end
            end
            dfc_pkg::ST_WALK:
            begin
                if (walk_end && (tree_reg == last_reg))
                begin
                    state_next = dfc_pkg::ST_DONE;
                end
            end
            dfc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = dfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dfc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory reads, walk position and votes.
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        vote_ctl   = '0;
        tree_next  = tree_reg;
        last_next  = last_reg;
        slot_next  = slot_reg;
        depth_next = depth_reg;
        out_load   = 1'b0;
        case (state_reg)
            dfc_pkg::ST_IDLE:
            begin
                if (s_tvalid && is_classify)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = '0;
                    tree_next      = '0;
                    last_next      = n_last;
                    slot_next      = '0;
                    depth_next     = '0;
                    vote_ctl.clear = 1'b1;
                end
            end
            dfc_pkg::ST_WALK:
            begin
                vote_ctl.inc = walk_end;
                vote_ctl.cls = leaf_class;
                if (walk_end)
                begin
                    if (tree_reg != last_reg)
                    begin
                        tree_next  = tree_reg + TREE_W'(1);
                        slot_next  = '0;
                        depth_next = '0;
                        rd_en      = 1'b1;
                        rd_addr    = {tree_reg + TREE_W'(1), SLOT_W'(0)};
                    end
                end
                else
                begin
                    slot_next  = child_slot;
                    depth_next = depth_reg + DEPTH_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = {tree_reg, child_slot};
                end
            end
            dfc_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dfc_pkg::ST_IDLE;
            tree_count_reg <= dfc_pkg::TREE_COUNT_RESET;
            tree_reg       <= '0;
            last_reg       <= '0;
            slot_reg       <= '0;
            depth_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tree_reg  <= tree_next;
            last_reg  <= last_next;
            slot_reg  <= slot_next;
            depth_reg <= depth_next;
            if (cfg_we)
            begin
                tree_count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Sample features and result payload.
    always_ff @(posedge clk)
    begin
        if (s_accept && is_classify)
        begin
            feat_reg[0] <= s_tdata[44:29];
            feat_reg[1] <= s_tdata[60:45];
            feat_reg[2] <= s_tdata[76:61];
            feat_reg[3] <= s_tdata[92:77];
        end
        if (out_load)
        begin
            m_class_reg <= best_class;
            m_votes_reg <= best_votes;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, 4'(m_votes_reg), m_class_reg};

    dfc_node_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_node_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_node),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (node)
    );

    dfc_vote_tally #(
        .VOTE_W (VOTE_W)
    ) u_vote_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (vote_ctl),
        .best_class (best_class),
        .best_votes (best_votes)
    );

    // The walk never goes past the leaf level.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfc_pkg::ST_WALK) |-> (depth_reg <= DEPTH_W'(TREE_DEPTH)))
        else $error("walk depth beyond maximum");

    // The walk stays within the voting trees.
    a_tree: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfc_pkg::ST_WALK) |-> (tree_reg <= last_reg))
        else $error("walk beyond last voting tree");

    // A result appears only after a finished walk.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == dfc_pkg::ST_DONE))
        else $error("result without finished walk");

    // The winning class always holds at least one vote.
    a_votes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_votes_reg != '0))
        else $error("result with zero winning votes");

endmodule
